/* rtl/core/vgq_pkg.sv */
// Shared widths, defaults and register codes for the voxel grid quantizer.
// No dependencies; compile before every other file of the block.
package vgq_pkg;

    localparam int COORD_W       = 32;
    localparam int CELL_W        = 16;
    localparam int LEVEL_W       = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int NUM_AXES      = 3;
    localparam int MAX_LEVEL_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X      = 3'd0,
        REG_MIN_Y      = 3'd1,
        REG_MIN_Z      = 3'd2,
        REG_CELL_SIZE  = 3'd3,
        REG_GRID_LEVEL = 3'd4
    } cfg_reg_t;

endpackage

/* rtl/core/vgq_if.sv */
// Valid/ready channel interfaces for points in and voxel cells out.
// Depends on vgq_pkg for field widths.
interface vgq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vgq_pkg::COORD_W-1:0]   point_x;
    logic signed [vgq_pkg::COORD_W-1:0]   point_y;
    logic signed [vgq_pkg::COORD_W-1:0]   point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vgq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [vgq_pkg::CELL_W-1:0]           cell_x;
    logic [vgq_pkg::CELL_W-1:0]           cell_y;
    logic [vgq_pkg::CELL_W-1:0]           cell_z;
    logic [vgq_pkg::LEVEL_W-1:0]          key_level;

    modport source (output valid, cell_x, cell_y, cell_z, key_level, input ready);
    modport sink   (input valid, cell_x, cell_y, cell_z, key_level, output ready);
endinterface

/* rtl/core/voxel_grid_quantizer.sv */
// Voxel grid quantizer: maps each point to its clamped voxel cell index.
// Registers on the way: origin subtract, range check, one divider stage per quotient
// bit in each axis lane, then the output item. Throughput: one item per cycle while
// the output is not stalled, set by the pipelined restoring divider, which resolves
// one quotient bit per stage. Reset (async, active low) empties the pipeline and
// loads the register defaults: origin 0, cell size 1, grid level 1.
module voxel_grid_quantizer #(
    parameter int MAX_LEVEL = vgq_pkg::MAX_LEVEL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vgq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vgq_pkg::CFG_DATA_W-1:0]    cfg_data,
    vgq_in_if.sink                            points,
    vgq_out_if.source                         cells
);
    import vgq_pkg::*;

    localparam int NS = MAX_LEVEL + 2;

    logic signed [COORD_W-1:0] min_reg [NUM_AXES];
    logic [COORD_W-1:0]        cell_size_reg;
    logic [LEVEL_W-1:0]        grid_level_reg;

    logic [COORD_W-1:0]        cs_eff;
    logic [LEVEL_W-1:0]        lv_eff;

    logic [NS-1:0]             v_reg;
    logic [NS-1:0]             take;
    logic                      out_load;

    logic signed [COORD_W-1:0] coord [NUM_AXES];
    logic [NUM_AXES-1:0]       lane_neg;
    logic [NUM_AXES-1:0]       lane_sat;
    logic [MAX_LEVEL-1:0]      lane_quo [NUM_AXES];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                min_reg[i] <= '0;
            cell_size_reg  <= COORD_W'(1);
            grid_level_reg <= LEVEL_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_X:      min_reg[0]     <= cfg_data;
                REG_MIN_Y:      min_reg[1]     <= cfg_data;
                REG_MIN_Z:      min_reg[2]     <= cfg_data;
                REG_CELL_SIZE:  cell_size_reg  <= cfg_data;
                REG_GRID_LEVEL: grid_level_reg <= cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Treat a zero cell size as one and saturate the level
    assign cs_eff = (cell_size_reg == '0) ? COORD_W'(1) : cell_size_reg;
    assign lv_eff = (grid_level_reg > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                           : grid_level_reg;

    // A stage may load when it or any stage after it holds a bubble, or when the output register loads
    for (genvar s = 0; s < NS; s++)
    begin : g_take
        assign take[s] = out_load || !(&v_reg[NS-1:s]);
    end

    assign points.ready = take[0];

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (take[0])
                v_reg[0] <= points.valid;
            for (int s = 1; s < NS; s++)
            begin
                if (take[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign coord[0] = points.point_x;
    assign coord[1] = points.point_y;
    assign coord[2] = points.point_z;

    // One divider lane per axis
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        vgq_lane #(
            .MAX_LEVEL (MAX_LEVEL)
        ) u_lane (
            .clk    (clk),
            .en     (take),
            .coord  (coord[a]),
            .origin (min_reg[a]),
            .cs     (cs_eff),
            .neg    (lane_neg[a]),
            .sat    (lane_sat[a]),
            .quo    (lane_quo[a])
        );
    end

    vgq_merge #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .v_in  (v_reg[NS-1]),
        .neg   (lane_neg),
        .sat   (lane_sat),
        .quo   (lane_quo),
        .level (lv_eff),
        .load  (out_load),
        .cells (cells)
    );

endmodule

/* rtl/core/vgq_lane.sv */
// One axis lane: origin subtract, range check and a pipelined restoring
// divider that yields one quotient bit per stage. Depends on vgq_pkg.
module vgq_lane #(
    parameter int MAX_LEVEL = vgq_pkg::MAX_LEVEL_DEF
) (
    input  logic                                clk,
    input  logic [MAX_LEVEL+1:0]                en,
    input  logic signed [vgq_pkg::COORD_W-1:0]  coord,
    input  logic signed [vgq_pkg::COORD_W-1:0]  origin,
    input  logic [vgq_pkg::COORD_W-1:0]         cs,
    output logic                                neg,
    output logic                                sat,
    output logic [MAX_LEVEL-1:0]                quo
);
    import vgq_pkg::*;

    localparam int W = COORD_W + MAX_LEVEL;

    logic signed [COORD_W:0] diff;
    logic                    neg0_reg;
    logic [COORD_W-1:0]      rem0_reg;
    logic [W-1:0]            dvs_full;
    logic                    sat_cmp;

    logic [COORD_W-1:0]      rem_reg [0:MAX_LEVEL];
    logic [MAX_LEVEL-1:0]    quo_reg [0:MAX_LEVEL];
    logic                    neg_reg [0:MAX_LEVEL];
    logic                    sat_reg [0:MAX_LEVEL];

    // Take the 33-bit difference; a non-negative one always fits 32 bits
    assign diff = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg0_reg <= diff[COORD_W];
            rem0_reg <= diff[COORD_W-1:0];
        end
    end

    // Flag quotients that reach 2^MAX_LEVEL or beyond
    assign dvs_full = {cs, {MAX_LEVEL{1'b0}}};
    assign sat_cmp  = {{MAX_LEVEL{1'b0}}, rem0_reg} >= dvs_full;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            neg_reg[0] <= neg0_reg;
            sat_reg[0] <= sat_cmp;
            rem_reg[0] <= rem0_reg;
            quo_reg[0] <= '0;
        end
    end

    // Resolve one quotient bit per stage, most significant first
    for (genvar k = 0; k < MAX_LEVEL; k++)
    begin : g_bit
        localparam int SH = MAX_LEVEL - 1 - k;
        logic [W-1:0] dvs;
        logic         hit;

        assign dvs = W'(cs) << SH;
        assign hit = {{MAX_LEVEL{1'b0}}, rem_reg[k]} >= dvs;

        always_ff @(posedge clk)
        begin
            if (en[k+2])
            begin
                neg_reg[k+1] <= neg_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                rem_reg[k+1] <= hit ? (rem_reg[k] - dvs[COORD_W-1:0]) : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (hit ? (MAX_LEVEL'(1) << SH) : '0);
            end
        end
    end

    assign neg = neg_reg[MAX_LEVEL];
    assign sat = sat_reg[MAX_LEVEL];
    assign quo = quo_reg[MAX_LEVEL];

endmodule

/* rtl/core/vgq_merge.sv */
// Merge stage: clamps the three lane quotients to the grid and holds the
// output item. Depends on vgq_pkg and vgq_out_if.
module vgq_merge #(
    parameter int MAX_LEVEL = vgq_pkg::MAX_LEVEL_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          v_in,
    input  logic [vgq_pkg::NUM_AXES-1:0]  neg,
    input  logic [vgq_pkg::NUM_AXES-1:0]  sat,
    input  logic [MAX_LEVEL-1:0]          quo [vgq_pkg::NUM_AXES],
    input  logic [vgq_pkg::LEVEL_W-1:0]   level,
    output logic                          load,
    vgq_out_if.source                     cells
);
    import vgq_pkg::*;

    logic [MAX_LEVEL:0]   span;
    logic [MAX_LEVEL-1:0] top_idx;
    logic [MAX_LEVEL-1:0] idx [NUM_AXES];
    logic [LEVEL_W-1:0]   key;

    logic                 valid_reg;
    logic [CELL_W-1:0]    cell_reg [NUM_AXES];
    logic [LEVEL_W-1:0]   key_reg;

    // Highest index on the grid: 2^level - 1
    assign span    = ((MAX_LEVEL+1)'(1) << level) - (MAX_LEVEL+1)'(1);
    assign top_idx = span[MAX_LEVEL-1:0];
    assign key     = (level == '0) ? LEVEL_W'(1) : level;

    // Clamp below the origin to zero and beyond the grid to the top cell
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (neg[i])
                idx[i] = '0;
            else if (sat[i] || (quo[i] > top_idx))
                idx[i] = top_idx;
            else
                idx[i] = quo[i];
        end
    end

    // Load a new item when the output is empty or being taken
    assign load = !valid_reg || cells.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (load && v_in)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                cell_reg[i] <= CELL_W'(idx[i]);
            key_reg <= key;
        end
    end

    assign cells.valid     = valid_reg;
    assign cells.cell_x    = cell_reg[0];
    assign cells.cell_y    = cell_reg[1];
    assign cells.cell_z    = cell_reg[2];
    assign cells.key_level = key_reg;

endmodule

/* rtl/core/vgq_checker.sv */
// Port-level checker for the voxel grid quantizer, with its bind statement.
// Depends on vgq_pkg and the top level voxel_grid_quantizer.
module vgq_checker #(
    parameter int MAX_LEVEL = vgq_pkg::MAX_LEVEL_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [vgq_pkg::CELL_W-1:0]    cell_x,
    input logic [vgq_pkg::CELL_W-1:0]    cell_y,
    input logic [vgq_pkg::CELL_W-1:0]    cell_z,
    input logic [vgq_pkg::LEVEL_W-1:0]   key_level
);
    import vgq_pkg::*;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] pend_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Track items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 32'(in_acc) - 32'(out_acc);
    end

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_x) && $stable(cell_y)
                                    && $stable(cell_z) && $stable(key_level))
        else $error("output item changed while stalled");

    // Deliver no item that was never accepted
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("output item without a pending input item");

    // Keep the key level inside the supported range
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_level >= 1 && key_level <= MAX_LEVEL)
        else $error("key level out of range");

    // Keep every index on the grid of the reported level
    a_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((32'(cell_x) >> key_level) == 0) && ((32'(cell_y) >> key_level) == 0)
                      && ((32'(cell_z) >> key_level) == 0))
        else $error("cell index beyond grid");

endmodule

bind voxel_grid_quantizer vgq_checker #(
    .MAX_LEVEL (MAX_LEVEL)
) u_vgq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .out_valid (cells.valid),
    .out_ready (cells.ready),
    .cell_x    (cells.cell_x),
    .cell_y    (cells.cell_y),
    .cell_z    (cells.cell_z),
    .key_level (cells.key_level)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for voxel_grid_quantizer: point items in, voxel cell items out.
// Depends on vgq_pkg, vgq_in_if/vgq_out_if and the voxel_grid_quantizer RTL.
module testbench;

    import vgq_pkg::*;

    localparam int LEVEL_CAP   = MAX_LEVEL_DEF;
    localparam int LATENCY     = MAX_LEVEL_DEF + 3;
    localparam int SETTLE      = LATENCY + 8;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        bit [CELL_W-1:0]  cx;
        bit [CELL_W-1:0]  cy;
        bit [CELL_W-1:0]  cz;
        bit [LEVEL_W-1:0] level;
    } cell_item_t;

    // Predict voxel cells from accepted points and match them against the cell items
    class cell_ledger;
        bit signed [COORD_W-1:0] origin [NUM_AXES];
        bit [CFG_DATA_W-1:0]     cell_len;
        bit [LEVEL_W-1:0]        level_reg;
        cell_item_t              expected_cells [$];
        int                      mismatches;

        function new();
            origin     = '{0, 0, 0};
            cell_len   = 1;
            level_reg  = 1;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_X:      origin[0] = data;
                REG_MIN_Y:      origin[1] = data;
                REG_MIN_Z:      origin[2] = data;
                REG_CELL_SIZE:  cell_len  = data;
                REG_GRID_LEVEL: level_reg = data[LEVEL_W-1:0];
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        // Floor-divide the offset from the origin, then clamp into the grid
        function bit [CELL_W-1:0] quantize(bit signed [COORD_W-1:0] coord,
                                           bit signed [COORD_W-1:0] base, int lv);
            longint diff;
            longint divisor;
            longint q;
            longint top;
            diff    = longint'(coord) - longint'(base);
            divisor = (cell_len == 0) ? 64'sd1 : longint'({32'd0, cell_len});
            if (diff >= 0)
                q = diff / divisor;
            else
                q = -((-diff + divisor - 1) / divisor);
            top = (longint'(1) << lv) - 1;
            if (q < 0)
                q = 0;
            if (q > top)
                q = top;
            return CELL_W'(q);
        endfunction

        function void take_point(bit signed [COORD_W-1:0] x, bit signed [COORD_W-1:0] y,
                                 bit signed [COORD_W-1:0] z);
            cell_item_t c;
            int lv;
            lv      = (level_reg > LEVEL_CAP) ? LEVEL_CAP : int'(level_reg);
            c.cx    = quantize(x, origin[0], lv);
            c.cy    = quantize(y, origin[1], lv);
            c.cz    = quantize(z, origin[2], lv);
            c.level = (lv < 1) ? LEVEL_W'(1) : LEVEL_W'(lv);
            expected_cells.push_back(c);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void match_cell(cell_item_t got);
            cell_item_t want;
            if (expected_cells.size() == 0)
            begin
                flag($sformatf("cell item with none pending: x=%0d y=%0d z=%0d level=%0d",
                               got.cx, got.cy, got.cz, got.level));
                return;
            end
            want = expected_cells.pop_front();
            if (got.cx != want.cx)
                flag($sformatf("cell_x expected %0d got %0d", want.cx, got.cx));
            if (got.cy != want.cy)
                flag($sformatf("cell_y expected %0d got %0d", want.cy, got.cy));
            if (got.cz != want.cz)
                flag($sformatf("cell_z expected %0d got %0d", want.cz, got.cz));
            if (got.level != want.level)
                flag($sformatf("key_level expected %0d got %0d", want.level, got.level));
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    bit                      sender_burst;
    bit                      sink_burst;
    cell_ledger              ledger;

    vgq_in_if  point_ch ();
    vgq_out_if cell_ch ();

    voxel_grid_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (point_ch),
        .cells     (cell_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Take cell items, with random stalls outside sink bursts, and check each against the oldest prediction
    initial
    begin
        cell_item_t got;
        int stall;
        cell_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                cell_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cell_ch.ready <= 1'b1;
            @(posedge clk);
            while (!cell_ch.valid)
                @(posedge clk);
            got.cx    = cell_ch.cell_x;
            got.cy    = cell_ch.cell_y;
            got.cz    = cell_ch.cell_z;
            got.level = cell_ch.key_level;
            ledger.match_cell(got);
        end
    end

    task automatic send_point(bit signed [COORD_W-1:0] x, bit signed [COORD_W-1:0] y,
                              bit signed [COORD_W-1:0] z);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        point_ch.point_z <= z;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        ledger.take_point(x, y, z);
    endtask

    task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        ledger.write_reg(idx, data);
    endtask

    // Hold points back until every predicted cell has come out
    task automatic wait_idle();
        point_ch.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(bit [31:0] mx, bit [31:0] my, bit [31:0] mz,
                                bit [31:0] cs, bit [LEVEL_W-1:0] lv);
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_MIN_X, mx);
        write_reg(REG_MIN_Y, my);
        write_reg(REG_MIN_Z, mz);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_GRID_LEVEL, {27'd0, lv});
        cfg_we <= 1'b0;
    endtask

    // Mostly land near the grid, one cell either side; sometimes anywhere
    function automatic bit [31:0] pick_coord(bit signed [31:0] base, bit [31:0] cs, int lv);
        longint eff;
        longint span_cell;
        longint sum;
        bit [31:0] within_max;
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        eff        = (cs == 0) ? 64'sd1 : longint'({32'd0, cs});
        within_max = 32'(eff - 1);
        span_cell  = $urandom_range(0, (1 << lv) + 1);
        sum        = longint'(base) + (span_cell - 1) * eff
                     + longint'({32'd0, $urandom_range(0, within_max)});
        return 32'(sum);
    endfunction

    initial
    begin
        bit [31:0]        mx, my, mz, cs;
        bit [LEVEL_W-1:0] lv;
        int               grid_lv;

        ledger           = new();
        sender_burst     = 1'b0;
        sink_burst       = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_MIN_X;
        cfg_data         <= '0;
        point_ch.valid   <= 1'b0;
        point_ch.point_x <= '0;
        point_ch.point_y <= '0;
        point_ch.point_z <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: origin 0, unit cells, two cells per axis
        send_point(0, 0, 0);
        send_point(1, 1, 1);
        send_point(2, -1, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, -1);

        // Extreme origins at the widest grid
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 16);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 65535);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 65536);
        send_point(32'h8000_FFFF, 32'h7FFF_FFFF, -1);

        // Zero cell size acts as one; level zero gives a single cell
        apply_config(0, 0, 0, 0, 0);
        send_point(5, -5, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 7);

        // Largest cell size; level above the cap saturates
        apply_config(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // Cell boundaries on both sides of the origin
        apply_config(100, -100, 0, 10, 3);
        send_point(99, -101, -1);
        send_point(100, -100, 0);
        send_point(109, -91, 79);
        send_point(110, -20, 80);
        send_point(90, -110, -10);

        // Random settings, each with a stream of random points
        for (int p = 0; p < PHASES; p++)
        begin
            lv = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            case ($urandom_range(0, 7))
                0:       cs = $urandom_range(0, 1);
                1:       cs = $urandom();
                2, 3:    cs = 32'd1 << $urandom_range(0, 31);
                default: cs = $urandom_range(1, 1 << $urandom_range(1, 16));
            endcase
            mx = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000) - 1000;
            my = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000) - 1000;
            mz = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000) - 1000;
            apply_config(mx, my, mz, cs, lv);
            sender_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
            grid_lv      = (lv > LEVEL_CAP) ? LEVEL_CAP : int'(lv);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_point(pick_coord(mx, cs, grid_lv), pick_coord(my, cs, grid_lv),
                           pick_coord(mz, cs, grid_lv));
            sender_burst = 1'b0;
            sink_burst   = 1'b0;
        end

        // Drain, give stray items time to show up, then report
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
